// ===== sv/clex_pkg.sv =====
// clex_pkg: shared types, codes, keyword table and character classifiers
// for the C subset lexer. Depends on nothing; every other file uses it.

package clex_pkg;

  localparam int MAX_TEXT_DEF      = 65536;
  localparam int KEYWORD_CHARS_DEF = 8;
  localparam int Q_DEPTH           = 2;
  localparam int NUM_KW            = 6;
  localparam int KW_MAX_LEN        = 8;
  localparam int KW_KIND_BASE      = 2;

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_IDLE    = 3'd0;
  localparam mode_t MODE_WORD    = 3'd1;
  localparam mode_t MODE_NUMBER  = 3'd2;
  localparam mode_t MODE_OP      = 3'd3;
  localparam mode_t MODE_COMMENT = 3'd4;
  localparam mode_t MODE_CSTAR   = 3'd5;

  typedef logic [5:0] kind_t;
  localparam kind_t K_IDENT    = 6'd0;
  localparam kind_t K_INTEGER  = 6'd1;
  localparam kind_t K_LPAREN   = 6'd8;
  localparam kind_t K_RPAREN   = 6'd9;
  localparam kind_t K_LBRACK   = 6'd10;
  localparam kind_t K_RBRACK   = 6'd11;
  localparam kind_t K_LBRACE   = 6'd12;
  localparam kind_t K_RBRACE   = 6'd13;
  localparam kind_t K_SEMI     = 6'd14;
  localparam kind_t K_ASSIGN   = 6'd15;
  localparam kind_t K_EQ       = 6'd16;
  localparam kind_t K_NOT      = 6'd17;
  localparam kind_t K_NE       = 6'd18;
  localparam kind_t K_PLUS     = 6'd19;
  localparam kind_t K_INC      = 6'd20;
  localparam kind_t K_PLUS_EQ  = 6'd21;
  localparam kind_t K_MINUS    = 6'd22;
  localparam kind_t K_DEC      = 6'd23;
  localparam kind_t K_MINUS_EQ = 6'd24;
  localparam kind_t K_ARROW    = 6'd25;
  localparam kind_t K_STAR     = 6'd26;
  localparam kind_t K_STAR_EQ  = 6'd27;
  localparam kind_t K_AMP      = 6'd28;
  localparam kind_t K_AND      = 6'd29;
  localparam kind_t K_SQUOTE   = 6'd30;
  localparam kind_t K_DQUOTE   = 6'd31;
  localparam kind_t K_DIV_EQ   = 6'd32;
  localparam kind_t K_SLASH    = 6'd33;
  localparam kind_t K_PERCENT  = 6'd34;
  localparam kind_t K_MOD_EQ   = 6'd35;
  localparam kind_t K_SHR      = 6'd36;
  localparam kind_t K_GE       = 6'd37;
  localparam kind_t K_GT       = 6'd38;
  localparam kind_t K_SHL      = 6'd39;
  localparam kind_t K_LE       = 6'd40;
  localparam kind_t K_LT       = 6'd41;
  localparam kind_t K_CARET    = 6'd42;
  localparam kind_t K_COMMA    = 6'd43;
  localparam kind_t K_QUEST    = 6'd44;
  localparam kind_t K_COLON    = 6'd45;
  localparam kind_t K_PIPE     = 6'd46;
  localparam kind_t K_OR       = 6'd47;

  localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "o", "t", "o", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "o", "n", "t", "i", "n", "u", "e"},
    '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd3, 4'd4, 4'd4, 4'd8, 4'd5, 4'd6};

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
  } token_t;

  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } step_t;

  typedef struct packed {
    logic  valid;
    step_t step;
  } q_head_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } kind_hit_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {["a":"z"], ["A":"Z"]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {["0":"9"]});
  endfunction

  function automatic kind_hit_t single_kind(input logic [7:0] c);
    kind_hit_t r;
    r.hit  = 1'b1;
    r.kind = K_IDENT;
    case (c)
      "(":  r.kind = K_LPAREN;
      ")":  r.kind = K_RPAREN;
      "[":  r.kind = K_LBRACK;
      "]":  r.kind = K_RBRACK;
      "{":  r.kind = K_LBRACE;
      "}":  r.kind = K_RBRACE;
      ";":  r.kind = K_SEMI;
      "'":  r.kind = K_SQUOTE;
      "\"": r.kind = K_DQUOTE;
      "^":  r.kind = K_CARET;
      ",":  r.kind = K_COMMA;
      "?":  r.kind = K_QUEST;
      ":":  r.kind = K_COLON;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // kind is K_IDENT when c opens no operator
  function automatic kind_hit_t op_alone(input logic [7:0] c);
    kind_hit_t r;
    r.hit  = 1'b1;
    r.kind = K_IDENT;
    case (c)
      "=": r.kind = K_ASSIGN;
      "!": r.kind = K_NOT;
      "+": r.kind = K_PLUS;
      "-": r.kind = K_MINUS;
      "*": r.kind = K_STAR;
      "&": r.kind = K_AMP;
      "/": r.kind = K_SLASH;
      "%": r.kind = K_PERCENT;
      ">": r.kind = K_GT;
      "<": r.kind = K_LT;
      "|": r.kind = K_PIPE;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic kind_hit_t op_pair(input logic [7:0] a, input logic [7:0] b);
    kind_hit_t r;
    r.hit  = 1'b0;
    r.kind = K_IDENT;
    case (a)
      "=": if (b == "=") r = '{hit: 1'b1, kind: K_EQ};
      "!": if (b == "=") r = '{hit: 1'b1, kind: K_NE};
      "+": begin
        if (b == "+") r = '{hit: 1'b1, kind: K_INC};
        else if (b == "=") r = '{hit: 1'b1, kind: K_PLUS_EQ};
      end
      "-": begin
        if (b == "-") r = '{hit: 1'b1, kind: K_DEC};
        else if (b == "=") r = '{hit: 1'b1, kind: K_MINUS_EQ};
        else if (b == ">") r = '{hit: 1'b1, kind: K_ARROW};
      end
      "*": if (b == "=") r = '{hit: 1'b1, kind: K_STAR_EQ};
      "&": if (b == "&") r = '{hit: 1'b1, kind: K_AND};
      "/": if (b == "=") r = '{hit: 1'b1, kind: K_DIV_EQ};
      "%": if (b == "=") r = '{hit: 1'b1, kind: K_MOD_EQ};
      ">": begin
        if (b == ">") r = '{hit: 1'b1, kind: K_SHR};
        else if (b == "=") r = '{hit: 1'b1, kind: K_GE};
      end
      "<": begin
        if (b == "<") r = '{hit: 1'b1, kind: K_SHL};
        else if (b == "=") r = '{hit: 1'b1, kind: K_LE};
      end
      "|": if (b == "|") r = '{hit: 1'b1, kind: K_OR};
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/clex_ifs.sv =====
// clex_ifs: valid/ready channel interfaces for characters in and tokens out.
// Depends on clex_pkg for the token kind type.

interface clex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface clex_out_if;
  logic                valid;
  logic                ready;
  clex_pkg::kind_t     token_kind;
  logic [15:0]         token_start;
  logic [15:0]         token_length;
  logic                run_last;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output run_last, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input run_last, output ready);
endinterface

// ===== sv/c_subset_lexer_core.sv =====
// c_subset_lexer_core: top level of the C subset lexer; scanner, step queue
// and token output stage. Depends on clex_pkg, clex_ifs and the clex modules.
//
//   channel   direction  word                                   handshake
//   in_chan   in         char_byte, end_of_text                 valid/ready
//   out_chan  out        token_kind, token_start, token_length, valid/ready
//                        run_last
//
// One character per cycle while the step queue has room; each token passes
// through the step queue into the output register, which passes on one
// token per cycle while out_chan.ready is high.
// A character that ends two tokens sends both through the output stage in
// turn; the two-record queue takes up the gap, and in_chan.ready drops only
// while it is full.
// Reset is synchronous and clears scanner mode, position, word count, queue
// pointers and output valid; there is no clearing pass.

module c_subset_lexer_core #(
  parameter int MAX_TEXT      = clex_pkg::MAX_TEXT_DEF,
  parameter int KEYWORD_CHARS = clex_pkg::KEYWORD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  clex_in_if.sink    in_chan,
  clex_out_if.source out_chan
);

  logic              q_ready;
  logic              push;
  clex_pkg::step_t   push_step;
  clex_pkg::q_head_t head;
  logic              pop;

  clex_front #(
    .MAX_TEXT      (MAX_TEXT),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .q_ready   (q_ready),
    .push      (push),
    .push_step (push_step)
  );

  clex_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_step (push_step),
    .q_ready   (q_ready),
    .head      (head),
    .pop       (pop)
  );

  clex_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("output valid after reset");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.token_length != 16'd0)
    else $error("token of zero length");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && !out_chan.run_last) |=> out_chan.valid)
    else $error("second token of a step missing");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_ready)
    else $error("push into full queue");

endmodule

// ===== sv/clex_front.sv =====
// clex_front: scanner state machine; takes one character per cycle while the
// queue has room and pushes the zero to two tokens it finishes as one step
// record. Depends on clex_pkg and clex_in_if.

module clex_front #(
  parameter int MAX_TEXT      = clex_pkg::MAX_TEXT_DEF,
  parameter int KEYWORD_CHARS = clex_pkg::KEYWORD_CHARS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  clex_in_if.sink          in_chan,
  input  logic             q_ready,
  output logic             push,
  output clex_pkg::step_t  push_step
);

  localparam logic [15:0] POS_LIMIT =
    (MAX_TEXT - 1 > 65535) ? 16'hFFFF : 16'(MAX_TEXT - 1);
  localparam int CW = $clog2(KEYWORD_CHARS + 2);
  localparam int IW = $clog2(KEYWORD_CHARS);

  logic [15:0]          pos_r, pos_nxt;
  logic [15:0]          begin_r, begin_nxt;
  clex_pkg::mode_t      mode_r, mode_nxt;
  logic [7:0]           pend_r, pend_nxt;
  logic [7:0]           wbuf_r [KEYWORD_CHARS];
  logic [7:0]           wbuf_nxt [KEYWORD_CHARS];
  logic [CW-1:0]        wcnt_r, wcnt_nxt;

  logic                 accept;
  logic [7:0]           c;
  logic                 do_idle;
  logic                 v0, v1, v2;
  clex_pkg::token_t     t0, t1, t2;
  logic [8*clex_pkg::KW_MAX_LEN-1:0] head_cur, head_nxt;
  clex_pkg::kind_hit_t  single_c, alone_c, alone_p, alone_pn, pair_pc;

  function automatic clex_pkg::kind_t word_kind(
    input logic [8*clex_pkg::KW_MAX_LEN-1:0] txt,
    input logic [CW-1:0]                     cnt
  );
    clex_pkg::kind_t k_out;
    logic            m;
    k_out = clex_pkg::K_IDENT;
    for (int k = 0; k < clex_pkg::NUM_KW; k++) begin
      m = (cnt == CW'(clex_pkg::KW_LEN[k]));
      for (int j = 0; j < clex_pkg::KW_MAX_LEN; j++) begin
        if (j < int'(clex_pkg::KW_LEN[k]) && txt[8*j +: 8] != clex_pkg::KW_TEXT[k][j]) begin
          m = 1'b0;
        end
      end
      if (m) begin
        k_out = clex_pkg::kind_t'(clex_pkg::KW_KIND_BASE + k);
      end
    end
    return k_out;
  endfunction

  function automatic logic [15:0] run_len(input logic [16:0] stop, input logic [15:0] beg);
    logic [16:0] d;
    d = stop - {1'b0, beg};
    if (stop > {1'b0, beg}) begin
      return d[16] ? 16'hFFFF : d[15:0];
    end
    return 16'd1;
  endfunction

  assign in_chan.ready = q_ready;
  assign accept        = in_chan.valid && q_ready;
  assign c             = in_chan.char_byte;

  always_comb begin
    mode_nxt  = mode_r;
    begin_nxt = begin_r;
    pend_nxt  = pend_r;
    wcnt_nxt  = wcnt_r;
    wbuf_nxt  = wbuf_r;
    pos_nxt   = pos_r;
    do_idle   = 1'b0;
    v0 = 1'b0;
    v1 = 1'b0;
    v2 = 1'b0;
    t0 = '0;
    t1 = '0;
    t2 = '0;
    single_c = clex_pkg::single_kind(c);
    alone_c  = clex_pkg::op_alone(c);
    alone_p  = clex_pkg::op_alone(pend_r);
    pair_pc  = clex_pkg::op_pair(pend_r, c);
    for (int j = 0; j < clex_pkg::KW_MAX_LEN; j++) begin
      head_cur[8*j +: 8] = wbuf_r[j];
    end

    case (mode_r)
      clex_pkg::MODE_WORD: begin
        if (clex_pkg::is_alpha(c) || clex_pkg::is_digit(c)) begin
          if (wcnt_r < CW'(KEYWORD_CHARS)) wbuf_nxt[wcnt_r[IW-1:0]] = c;
          if (wcnt_r <= CW'(KEYWORD_CHARS)) wcnt_nxt = wcnt_r + CW'(1);
        end else begin
          v0        = 1'b1;
          t0.kind   = word_kind(head_cur, wcnt_r);
          t0.start  = begin_r;
          t0.length = run_len({1'b0, pos_r}, begin_r);
          do_idle   = 1'b1;
        end
      end
      clex_pkg::MODE_NUMBER: begin
        if (!clex_pkg::is_digit(c)) begin
          v0        = 1'b1;
          t0.kind   = clex_pkg::K_INTEGER;
          t0.start  = begin_r;
          t0.length = run_len({1'b0, pos_r}, begin_r);
          do_idle   = 1'b1;
        end
      end
      clex_pkg::MODE_OP: begin
        if (pend_r == "/" && c == "*") begin
          mode_nxt = clex_pkg::MODE_COMMENT;
        end else if (pair_pc.hit) begin
          v0        = 1'b1;
          t0.kind   = pair_pc.kind;
          t0.start  = begin_r;
          t0.length = 16'd2;
          mode_nxt  = clex_pkg::MODE_IDLE;
        end else begin
          v0        = 1'b1;
          t0.kind   = alone_p.kind;
          t0.start  = begin_r;
          t0.length = 16'd1;
          do_idle   = 1'b1;
        end
      end
      clex_pkg::MODE_COMMENT: begin
        if (c == "*") mode_nxt = clex_pkg::MODE_CSTAR;
      end
      clex_pkg::MODE_CSTAR: begin
        if (c == "/") mode_nxt = clex_pkg::MODE_IDLE;
        else if (c != "*") mode_nxt = clex_pkg::MODE_COMMENT;
      end
      default: do_idle = 1'b1;
    endcase

    if (do_idle) begin
      mode_nxt = clex_pkg::MODE_IDLE;
      if (clex_pkg::is_alpha(c)) begin
        mode_nxt    = clex_pkg::MODE_WORD;
        begin_nxt   = pos_r;
        wbuf_nxt[0] = c;
        wcnt_nxt    = CW'(1);
      end else if (clex_pkg::is_digit(c)) begin
        mode_nxt  = clex_pkg::MODE_NUMBER;
        begin_nxt = pos_r;
      end else if (single_c.hit) begin
        v1        = 1'b1;
        t1.kind   = single_c.kind;
        t1.start  = pos_r;
        t1.length = 16'd1;
      end else if (alone_c.hit) begin
        mode_nxt  = clex_pkg::MODE_OP;
        begin_nxt = pos_r;
        pend_nxt  = c;
      end
    end

    for (int j = 0; j < clex_pkg::KW_MAX_LEN; j++) begin
      head_nxt[8*j +: 8] = wbuf_nxt[j];
    end
    alone_pn = clex_pkg::op_alone(pend_nxt);

    if (in_chan.end_of_text) begin
      case (mode_nxt)
        clex_pkg::MODE_WORD: begin
          v2        = 1'b1;
          t2.kind   = word_kind(head_nxt, wcnt_nxt);
          t2.start  = begin_nxt;
          t2.length = run_len({1'b0, pos_r} + 17'd1, begin_nxt);
        end
        clex_pkg::MODE_NUMBER: begin
          v2        = 1'b1;
          t2.kind   = clex_pkg::K_INTEGER;
          t2.start  = begin_nxt;
          t2.length = run_len({1'b0, pos_r} + 17'd1, begin_nxt);
        end
        clex_pkg::MODE_OP: begin
          v2        = 1'b1;
          t2.kind   = alone_pn.kind;
          t2.start  = begin_nxt;
          t2.length = 16'd1;
        end
        default: v2 = 1'b0;
      endcase
      pos_nxt   = '0;
      begin_nxt = '0;
      mode_nxt  = clex_pkg::MODE_IDLE;
      pend_nxt  = '0;
      wcnt_nxt  = '0;
    end else if (pos_r < POS_LIMIT) begin
      pos_nxt = pos_r + 16'd1;
    end
  end

  // pack: a single-char token never shares a step with an end-of-text flush
  always_comb begin
    push           = accept && (v0 || v1 || v2);
    push_step.two  = (v0 && v1) || (v0 && v2);
    push_step.tok0 = v0 ? t0 : (v1 ? t1 : t2);
    push_step.tok1 = (v0 && v1) ? t1 : t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      mode_r <= clex_pkg::MODE_IDLE;
      wcnt_r <= '0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      mode_r <= mode_nxt;
      wcnt_r <= wcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      begin_r <= begin_nxt;
      pend_r  <= pend_nxt;
      wbuf_r  <= wbuf_nxt;
    end
  end

endmodule

// ===== sv/clex_queue.sv =====
// clex_queue: short FIFO of step records between scanner and token output.
// Depends on clex_pkg.

module clex_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  clex_pkg::step_t   push_step,
  output logic              q_ready,
  output clex_pkg::q_head_t head,
  input  logic              pop
);

  localparam int PW = (clex_pkg::Q_DEPTH > 1) ? $clog2(clex_pkg::Q_DEPTH) : 1;
  localparam int NW = $clog2(clex_pkg::Q_DEPTH + 1);

  clex_pkg::step_t mem_r [clex_pkg::Q_DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic            do_pop;

  assign q_ready    = (cnt_r != NW'(clex_pkg::Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.step  = mem_r[rptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(clex_pkg::Q_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(clex_pkg::Q_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !do_pop) cnt_nxt = cnt_r + NW'(1);
    else if (!push && do_pop) cnt_nxt = cnt_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_step;
  end

endmodule

// ===== sv/clex_back.sv =====
// clex_back: unpacks step records into single tokens and holds each in an
// output register until taken. Depends on clex_pkg and clex_out_if.

module clex_back (
  input  logic              clk,
  input  logic              rst_n,
  input  clex_pkg::q_head_t head,
  output logic              pop,
  clex_out_if.source        out_chan
);

  logic             out_valid_r;
  clex_pkg::token_t out_tok_r;
  logic             out_last_r;
  logic             idx_r;
  logic             load;

  assign load = !out_valid_r || out_chan.ready;
  assign pop  = load && head.valid && (idx_r || !head.step.two);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 1'b0;
    end else if (load) begin
      out_valid_r <= head.valid;
      if (head.valid) idx_r <= head.step.two && !idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head.valid) begin
      out_tok_r  <= idx_r ? head.step.tok1 : head.step.tok0;
      out_last_r <= idx_r || !head.step.two;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.token_kind   = out_tok_r.kind;
  assign out_chan.token_start  = out_tok_r.start;
  assign out_chan.token_length = out_tok_r.length;
  assign out_chan.run_last     = out_last_r;

endmodule
